### rtl/core/volume_render_weights_unit_defines.svh
// Assertion macros for the volume render weights unit
`ifndef VOLUME_RENDER_WEIGHTS_UNIT_DEFINES_SVH
`define VOLUME_RENDER_WEIGHTS_UNIT_DEFINES_SVH

// pre holds now implies post holds now, outside reset
`define VRW_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// pre holds now implies post holds in the next cycle, outside reset
`define VRW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

// checked through reset as well
`define VRW_ASSERT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/vrw_pkg.sv
// Shared types, constants and exp tables for the volume render weights unit
`timescale 1ns / 1ps
package vrw_pkg;

  localparam int MAX_SAMPLES_DEF    = 256;
  localparam int EXP_TABLE_BITS_DEF = 10;
  localparam int QDEPTH             = 4;
  localparam int QPTR_W             = 2;
  localparam logic [31:0] HUGE_INTERVAL = 32'hFFFF_FFFF;
  localparam logic [24:0] ONE_Q24       = 25'd16777216;

  typedef struct packed {
    logic [31:0] density;
    logic [31:0] interval;
    logic [7:0]  index;
    logic        done;
    logic        first;
  } vrw_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MASS,
    BK_EXP,
    BK_MUL,
    BK_OUT
  } vrw_bstate_t;

  function automatic logic [24:0] int_exp(input logic [3:0] ip);
    logic [24:0] v;
    case (ip)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd6171993;
      4'd2:    v = 25'd2270549;
      4'd3:    v = 25'd835288;
      4'd4:    v = 25'd307285;
      4'd5:    v = 25'd113044;
      4'd6:    v = 25'd41587;
      4'd7:    v = 25'd15299;
      4'd8:    v = 25'd5628;
      4'd9:    v = 25'd2070;
      4'd10:   v = 25'd762;
      4'd11:   v = 25'd280;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  function automatic logic [23:0] frac_exp(input logic [4:0] k);
    logic [23:0] v;
    case (k)
      5'd1:    v = 24'd10175896;
      5'd2:    v = 24'd13066109;
      5'd3:    v = 24'd14805841;
      5'd4:    v = 24'd15760736;
      5'd5:    v = 24'd16261035;
      5'd6:    v = 24'd16517109;
      5'd7:    v = 24'd16646655;
      5'd8:    v = 24'd16711808;
      5'd9:    v = 24'd16744480;
      5'd10:   v = 24'd16760840;
      5'd11:   v = 24'd16769026;
      5'd12:   v = 24'd16773120;
      5'd13:   v = 24'd16775168;
      5'd14:   v = 24'd16776192;
      5'd15:   v = 24'd16776704;
      5'd16:   v = 24'd16776960;
      default: v = 24'd16777215;
    endcase
    return v;
  endfunction

  // starting point of exp(-x): integer part only, zero from 12.0 up
  function automatic logic [24:0] exp_seed(input logic [31:0] x);
    logic [24:0] v;
    if (x[31:20] != 12'd0) v = 25'd0;
    else v = int_exp(x[19:16]);
    return v;
  endfunction

endpackage

### rtl/core/volume_render_weights_unit.sv
// Top level of the volume render weights unit
//
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_sample_depth, in_density, in_last_in_ray
//  out     | output    | out_valid, out_stall, out_weight, out_sample_index, out_ray_done
//
// In the back end each weight passes the mass, exp, multiply and output steps:
// both exp evaluations share one table multiplier, one fraction bit per cycle.
// A sample yields zero, one or two weights; the front keeps accepting while
// the four-entry job queue has room and no second job of a sample is waiting.
// Reset is synchronous, active low, and clears held sample, queue and output.
// A stalled output holds the back end; the queue then fills and stalls the input.
`timescale 1ns / 1ps
module volume_render_weights_unit #(
  parameter int MAX_SAMPLES    = vrw_pkg::MAX_SAMPLES_DEF,
  parameter int EXP_TABLE_BITS = vrw_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_depth,
  input  logic [31:0] in_density,
  input  logic        in_last_in_ray,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_weight,
  output logic [7:0]  out_sample_index,
  output logic        out_ray_done
);
  import vrw_pkg::*;

  logic     push_valid, q_full, q_empty, pop;
  vrw_job_t push_job, pop_job;

  vrw_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample_depth, .in_density,
    .in_last_in_ray, .q_full, .push_valid, .push_job
  );

  vrw_queue u_queue (
    .clk, .rst_n, .push_valid, .push_job, .q_full, .pop, .q_empty, .pop_job
  );

  vrw_back #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
    .clk, .rst_n, .q_empty, .pop_job, .pop, .out_valid, .out_stall,
    .out_weight, .out_sample_index, .out_ray_done
  );

endmodule

### rtl/core/vrw_front.sv
// Front end: holds one sample back and turns samples into weight jobs
`timescale 1ns / 1ps
module vrw_front #(
  parameter int MAX_SAMPLES = vrw_pkg::MAX_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [31:0]      in_sample_depth,
  input  logic [31:0]      in_density,
  input  logic             in_last_in_ray,
  input  logic             q_full,
  output logic             push_valid,
  output vrw_pkg::vrw_job_t push_job
);
  import vrw_pkg::*;

  localparam int IndexCapI = (MAX_SAMPLES - 1) > 255 ? 255 : (MAX_SAMPLES - 1);
  localparam logic [8:0] IndexCap = 9'(IndexCapI);

  logic        holding_r, holding_nxt;
  logic        held_first_r, held_first_nxt;
  logic [31:0] held_depth_r, held_depth_nxt;
  logic [31:0] held_density_r, held_density_nxt;
  logic [7:0]  held_index_r, held_index_nxt;
  logic        pend_v_r, pend_v_nxt;
  vrw_job_t    pend_r, pend_nxt;

  logic        accept;
  logic [8:0]  idx_inc;
  logic [7:0]  idx;
  vrw_job_t    held_job, last_job;

  assign in_stall = q_full | pend_v_r;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    idx_inc = {1'b0, held_index_r} + 9'd1;
    if (holding_r) begin
      idx = (idx_inc > IndexCap) ? IndexCap[7:0] : idx_inc[7:0];
    end else begin
      idx = 8'd0;
    end
    held_job.density  = held_density_r;
    held_job.interval = (in_sample_depth >= held_depth_r) ?
                        (in_sample_depth - held_depth_r) : 32'd0;
    held_job.index    = held_index_r;
    held_job.done     = 1'b0;
    held_job.first    = held_first_r;
    last_job.density  = in_density;
    last_job.interval = HUGE_INTERVAL;
    last_job.index    = idx;
    last_job.done     = 1'b1;
    last_job.first    = ~holding_r;
  end

  always_comb begin
    holding_nxt      = holding_r;
    held_first_nxt   = held_first_r;
    held_depth_nxt   = held_depth_r;
    held_density_nxt = held_density_r;
    held_index_nxt   = held_index_r;
    pend_v_nxt       = pend_v_r;
    pend_nxt         = pend_r;
    push_valid       = 1'b0;
    push_job         = pend_r;
    if (pend_v_r) begin
      if (!q_full) begin
        push_valid = 1'b1;
        pend_v_nxt = 1'b0;
      end
    end else if (accept) begin
      if (holding_r) begin
        push_valid = 1'b1;
        push_job   = held_job;
        if (in_last_in_ray) begin
          pend_v_nxt = 1'b1;
          pend_nxt   = last_job;
        end
      end else if (in_last_in_ray) begin
        push_valid = 1'b1;
        push_job   = last_job;
      end
      if (in_last_in_ray) begin
        holding_nxt = 1'b0;
      end else begin
        holding_nxt      = 1'b1;
        held_first_nxt   = ~holding_r;
        held_depth_nxt   = in_sample_depth;
        held_density_nxt = in_density;
        held_index_nxt   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      holding_r <= holding_nxt;
      pend_v_r  <= pend_v_nxt;
    end
    held_first_r   <= held_first_nxt;
    held_depth_r   <= held_depth_nxt;
    held_density_r <= held_density_nxt;
    held_index_r   <= held_index_nxt;
    pend_r         <= pend_nxt;
  end

endmodule

### rtl/core/vrw_queue.sv
// Small job queue between front end and back end
`timescale 1ns / 1ps
module vrw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  vrw_pkg::vrw_job_t push_job,
  output logic              q_full,
  input  logic              pop,
  output logic              q_empty,
  output vrw_pkg::vrw_job_t pop_job
);
  import vrw_pkg::*;

  vrw_job_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]    cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign q_full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign pop_job = mem_r[rd_r];
  assign do_push = push_valid & ~q_full;
  assign do_pop  = pop & ~q_empty;

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wr_r] <= push_job;
  end

endmodule

### rtl/core/vrw_back.sv
// Back end: mass, two table exps on a shared multiplier, weight, output register
`timescale 1ns / 1ps
module vrw_back #(
  parameter int EXP_TABLE_BITS = vrw_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  vrw_pkg::vrw_job_t pop_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [16:0]       out_weight,
  output logic [7:0]        out_sample_index,
  output logic              out_ray_done
);
  import vrw_pkg::*;

  localparam int KW = $clog2(EXP_TABLE_BITS + 1);
  localparam logic [KW-1:0] KLast = KW'(EXP_TABLE_BITS);

  vrw_bstate_t state_r, state_nxt;
  vrw_job_t    job_r;
  logic [31:0] acc_r, acc_use_r, mass_r;
  logic [24:0] e_r, t_r, alpha_r;
  logic [15:0] frac_r;
  logic [KW-1:0] k_r;
  logic        phase_r;
  logic        out_valid_r;
  logic [16:0] weight_r;
  logic [7:0]  index_r;
  logic        done_r;

  logic [63:0] mass_prod;
  logic [31:0] mass_val, acc_use, acc_sum;
  logic [48:0] e_prod;
  logic [24:0] e_step;
  logic [49:0] w_prod;
  logic [32:0] acc_wide;

  assign pop              = (state_r == BK_IDLE) & ~q_empty;
  assign out_valid        = out_valid_r;
  assign out_weight       = weight_r;
  assign out_sample_index = index_r;
  assign out_ray_done     = done_r;

  always_comb begin
    mass_prod = {32'd0, job_r.density} * {32'd0, job_r.interval};
    mass_val  = (mass_prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : mass_prod[47:16];
    acc_use   = job_r.first ? 32'd0 : acc_r;
    e_prod    = {24'd0, e_r} * {25'd0, frac_exp(5'(k_r))};
    e_prod    = e_prod + 49'd8388608;
    e_step    = frac_r[15] ? e_prod[48:24] : e_r;
    w_prod    = {25'd0, t_r} * {25'd0, alpha_r};
    w_prod    = w_prod + 50'h0_8000_0000;
    acc_wide  = {1'b0, acc_use_r} + {1'b0, mass_r};
    acc_sum   = acc_wide[32] ? 32'hFFFF_FFFF : acc_wide[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_MASS;
      BK_MASS: state_nxt = BK_EXP;
      BK_EXP:  if (k_r == KLast && phase_r) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_OUT;
      BK_OUT:  if (!out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_MUL) begin
        out_valid_r <= 1'b1;
        acc_r       <= acc_sum;
      end else if (state_r == BK_OUT && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    case (state_r)
      BK_IDLE: begin
        job_r <= pop_job;
      end
      BK_MASS: begin
        mass_r    <= mass_val;
        acc_use_r <= acc_use;
        e_r       <= exp_seed(acc_use);
        frac_r    <= acc_use[15:0];
        k_r       <= KW'(1);
        phase_r   <= 1'b0;
      end
      BK_EXP: begin
        if (k_r == KLast) begin
          if (!phase_r) begin
            t_r     <= e_step;
            e_r     <= exp_seed(mass_r);
            frac_r  <= mass_r[15:0];
            k_r     <= KW'(1);
            phase_r <= 1'b1;
          end else begin
            alpha_r <= ONE_Q24 - e_step;
          end
        end else begin
          e_r    <= e_step;
          frac_r <= {frac_r[14:0], 1'b0};
          k_r    <= k_r + 1'b1;
        end
      end
      BK_MUL: begin
        weight_r <= w_prod[48:32];
        index_r  <= job_r.index;
        done_r   <= job_r.done;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/vrw_checker.sv
// Port-level checks for the volume render weights unit
`timescale 1ns / 1ps
`include "volume_render_weights_unit_defines.svh"
module vrw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] out_weight,
  input logic [7:0]  out_sample_index,
  input logic        out_ray_done
);

  `VRW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_weight) && $stable(out_sample_index) && $stable(out_ray_done), "stalled result changed")
  `VRW_ASSERT_NOW(a_weight_range, out_valid, out_weight <= 17'd65536, "weight above one")
  `VRW_ASSERT_NEXT(a_gap_after_transfer, out_valid && !out_stall, !out_valid, "result repeated after transfer")
  `VRW_ASSERT_ALWAYS(a_reset_clears, !rst_n, !out_valid, "result valid after reset")

endmodule

bind volume_render_weights_unit vrw_checker u_vrw_checker (
  .clk, .rst_n, .out_valid, .out_stall,
  .out_weight, .out_sample_index, .out_ray_done
);

### tb/tb_top.sv
// Self-checking testbench for the volume render weights unit
`timescale 1ns / 1ps

class weight_scoreboard;
  bit          holding;
  logic [31:0] h_depth, h_dens, acc_mass;
  logic [7:0]  h_idx;
  logic [16:0] exp_w[$];
  logic [7:0]  exp_i[$];
  bit          exp_d[$];
  int          errors;

  function automatic logic [31:0] exp_neg(logic [31:0] x);
    logic [63:0] e;
    logic [31:0] itab[12];
    logic [31:0] ftab[17];
    itab = '{16777216, 6171993, 2270549, 835288, 307285, 113044,
             41587, 15299, 5628, 2070, 762, 280};
    ftab = '{16777216, 10175896, 13066109, 14805841, 15760736, 16261035,
             16517109, 16646655, 16711808, 16744480, 16760840, 16769026,
             16773120, 16775168, 16776192, 16776704, 16776960};
    if (x[31:16] >= 16'd12) return 32'd0;
    e = {32'd0, itab[x[19:16]]};
    for (int k = 1; k <= 10; k++)
      if (x[16-k]) e = (e * {32'd0, ftab[k]} + 64'h80_0000) >> 24;
    return e[31:0];
  endfunction

  function automatic logic [31:0] mass(logic [31:0] d, logic [31:0] iv);
    logic [63:0] p;
    p = ({32'd0, d} * {32'd0, iv}) >> 16;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic void push(logic [31:0] a, logic [31:0] m, logic [7:0] i, bit d);
    logic [63:0] t, al, w;
    t = {32'd0, exp_neg(a)};
    al = 64'd16777216 - {32'd0, exp_neg(m)};
    w = (t * al + 64'h8000_0000) >> 32;
    exp_w.push_back(w[16:0]); exp_i.push_back(i); exp_d.push_back(d);
  endfunction

  function void note_sample(logic [31:0] depth, logic [31:0] dens, bit last);
    logic [31:0] m, iv;
    logic [32:0] s;
    logic [7:0]  idx;
    if (holding) begin
      iv = (depth >= h_depth) ? depth - h_depth : 32'd0;
      m = mass(h_dens, iv);
      push(acc_mass, m, h_idx, 1'b0);
      s = {1'b0, acc_mass} + {1'b0, m};
      acc_mass = s[32] ? 32'hFFFF_FFFF : s[31:0];
      idx = (h_idx == 8'd255) ? 8'd255 : h_idx + 8'd1;
    end else begin
      acc_mass = 32'd0;
      idx = 8'd0;
    end
    if (last) begin
      push(acc_mass, mass(dens, 32'hFFFF_FFFF), idx, 1'b1);
      holding = 0; acc_mass = 32'd0;
    end else begin
      holding = 1; h_depth = depth; h_dens = dens; h_idx = idx;
    end
  endfunction

  function void check_weight(logic [16:0] w, logic [7:0] i, bit d);
    if (exp_w.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected transfer w=%0d idx=%0d done=%0b", w, i, d);
      return;
    end
    if (w !== exp_w[0] || i !== exp_i[0] || d !== exp_d[0]) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp w=%0d idx=%0d done=%0b, got w=%0d idx=%0d done=%0b",
                 exp_w[0], exp_i[0], exp_d[0], w, i, d);
    end
    void'(exp_w.pop_front()); void'(exp_i.pop_front()); void'(exp_d.pop_front());
  endfunction
endclass

module tb_top;
  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_stall, in_last_in_ray = 0;
  logic [31:0] in_sample_depth = 0, in_density = 0;
  logic        out_valid, out_stall = 0, out_ray_done;
  logic [16:0] out_weight;
  logic [7:0]  out_sample_index;
  weight_scoreboard sb = new();
  bit   quiet = 0;
  int   cycles = 0;
  logic [31:0] cur_depth;

  volume_render_weights_unit dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_weight(out_weight, out_sample_index, out_ray_done);
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  task automatic send(logic [31:0] depth, logic [31:0] dens, bit last);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1; in_sample_depth <= depth; in_density <= dens; in_last_in_ray <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(depth, dens, last);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_dens();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0000_FFFF);
      2: return 32'd0;
      default: return $urandom_range(0, 32'h0008_0000);
    endcase
  endfunction

  task automatic rand_ray(int len);
    for (int k = 0; k < len; k++) begin
      cur_depth = cur_depth + $urandom_range(0, 32'h0002_0000);
      if ($urandom_range(0, 30) == 0) cur_depth = $urandom;
      send(cur_depth, rand_dens(), k == len - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: single-sample rays, extremes, saturation, decreasing depth
    send(0, 0, 1);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send(0, 32'h0001_0000, 1);
    send(0, 32'h0001_0000, 0);
    send(32'h0001_0000, 32'h0000_8000, 0);
    send(32'h0000_8000, 32'h0002_0000, 0);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send(32'hFFFF_FFFF, 32'h0000_0001, 1);
    send(0, 32'hAAAA_5555, 0);
    send(32'h5555_AAAA, 32'h0000_FFFF, 0);
    send(32'h8000_0000, 32'h000B_FFFF, 1);
    cur_depth = 0;
    for (int k = 0; k < 300; k++) send(k * 32'h100, 32'h0000_4000 + k, k == 299);
    sent = 0;
    while (sent < 1600) begin
      int len;
      if (sent > 1300) quiet = 1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 40);
      cur_depth = $urandom_range(0, 32'h0010_0000);
      rand_ray(len);
      sent += len;
    end
    in_valid <= 0;
    while (sb.exp_w.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.exp_w.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
